FILE: rtl/core/bsm_pkg.sv
package bsm_pkg;

  localparam int CoordW = 32;
  localparam int RadW   = 31;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int LenW   = ProdW;
  localparam int RootW  = DiffW;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_MERGE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_CMP,
    S_ROOT,
    S_DIV,
    S_MOVE,
    S_RAD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
    logic             exact;
  } root_res_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] quot;
  } div_res_t;

endpackage

FILE: rtl/core/bounding_sphere_merge_top.sv
// Running 3D bounding sphere in Q16.16. A start request loads its sphere; a merge
// request grows the held sphere to enclose the new one. A start goes straight to the
// result; a merge where one sphere encloses the other ends after the squarings and the
// compare; a full merge runs 4 squarings on the shared 33x33 multiplier, a bit-per-cycle
// square root, a 33-step divider and 3 more multiplies for the center.
// One request is worked on at a time; a new request is taken while the previous
// result still waits on the output.
module bounding_sphere_merge_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      operation,
  input  logic signed [31:0]        in_center_x,
  input  logic signed [31:0]        in_center_y,
  input  logic signed [31:0]        in_center_z,
  input  logic [30:0]               in_radius,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic signed [31:0]        out_center_x,
  output logic signed [31:0]        out_center_y,
  output logic signed [31:0]        out_center_z,
  output logic [30:0]               out_radius,
  output logic                      grew,
  output logic                      saturated
);
  import bsm_pkg::*;

  state_t state, state_next;

  logic signed [CoordW-1:0] cur_c [3];
  logic [RadW-1:0]          cur_radius;
  logic signed [CoordW-1:0] new_c [3];
  logic [RadW-1:0]          new_radius;
  logic                     op;
  logic signed [DiffW-1:0]  d [3];
  logic [LenW-1:0]          lensq;
  logic [ProdW-1:0]         rdsq;
  logic [RootW-1:0]         s;
  logic                     exact;
  logic [RootW-1:0]         t;
  logic [2:0]               step;
  logic                     grew_r;
  logic                     sat_r;

  logic [DiffW-1:0]         mul_a;
  logic [DiffW-1:0]         mul_b;
  logic [ProdW-1:0]         prod;
  logic                     root_start;
  logic                     div_start;
  root_res_t                root_res;
  div_res_t                 div_res;
  logic [RootW:0]           div_num;
  logic [RadW-1:0]          rd;
  logic [DiffW-1:0]         mag [3];
  logic                     accept;
  logic                     out_free;
  logic [1:0]               pidx;
  logic [ProdW:0]           off_sum;
  logic signed [CoordW+3:0] moved;
  logic [RootW:0]           sc;
  logic [RootW+1:0]         rad_sum;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign pidx     = 2'(step - 3'd1);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = d[k][DiffW-1] ? DiffW'(-d[k]) : DiffW'(d[k]);
    end
    rd = (cur_radius > new_radius) ? cur_radius - new_radius : new_radius - cur_radius;
    div_num = (RootW+1)'(s) + (RootW+1)'(new_radius) - (RootW+1)'(cur_radius);
    off_sum = (ProdW+1)'(prod) + (ProdW+1)'(64'h8000_0000);
    if (d[pidx][DiffW-1]) begin
      moved = (CoordW+4)'(cur_c[pidx]) - (CoordW+4)'(off_sum[ProdW:32]);
    end else begin
      moved = (CoordW+4)'(cur_c[pidx]) + (CoordW+4)'(off_sum[ProdW:32]);
    end
    sc      = (RootW+1)'(s) + (RootW+1)'(!exact);
    rad_sum = (RootW+2)'(sc) + (RootW+2)'(cur_radius) + (RootW+2)'(new_radius)
              + (RootW+2)'(1);
  end

  // multiplier operand select: squares during S_SQ, offsets during S_MOVE
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_SQ) begin
      if (step == 3'd3) begin
        mul_a = DiffW'(rd);
      end else if (step < 3'd3) begin
        mul_a = mag[step[1:0]];
      end
      mul_b = mul_a;
    end else if (state == S_MOVE && step < 3'd3) begin
      mul_a = mag[step[1:0]];
      mul_b = t;
    end
  end

  bsm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  bsm_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (lensq),
    .res   (root_res)
  );

  bsm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = (state != S_IDLE);
    root_start = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (op_t'(operation) == OP_MERGE) ? S_SQ : S_DONE;
        end
      end
      S_SQ: begin
        if (step == 3'd4) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (lensq <= LenW'(rdsq)) begin
          state_next = S_DONE;
        end else begin
          root_start = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_res.done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step == 3'd0) begin
          div_start = 1'b1;
        end
        if (div_res.done) begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        if (step == 3'd3) begin
          state_next = S_RAD;
        end
      end
      S_RAD: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        cur_c[k] <= '0;
      end
      cur_radius <= '0;
      rsp_valid  <= 1'b0;
      step       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (accept) begin
            new_c[0]   <= in_center_x;
            new_c[1]   <= in_center_y;
            new_c[2]   <= in_center_z;
            new_radius <= in_radius;
            op         <= operation;
            grew_r     <= 1'b0;
            sat_r      <= 1'b0;
            lensq      <= '0;
            d[0]       <= DiffW'(in_center_x) - DiffW'(cur_c[0]);
            d[1]       <= DiffW'(in_center_y) - DiffW'(cur_c[1]);
            d[2]       <= DiffW'(in_center_z) - DiffW'(cur_c[2]);
            if (op_t'(operation) == OP_START) begin
              cur_c[0]   <= in_center_x;
              cur_c[1]   <= in_center_y;
              cur_c[2]   <= in_center_z;
              cur_radius <= in_radius;
            end
          end
        end
        S_SQ: begin
          if (step == 3'd4) begin
            rdsq <= prod;
            step <= '0;
          end else begin
            if (step != 3'd0) begin
              lensq <= lensq + prod;
            end
            step <= step + 3'd1;
          end
        end
        S_CMP: begin
          if (lensq <= LenW'(rdsq) && new_radius > cur_radius) begin
            for (int k = 0; k < 3; k++) begin
              cur_c[k] <= new_c[k];
            end
            cur_radius <= new_radius;
            grew_r     <= 1'b1;
          end
        end
        S_ROOT: begin
          if (root_res.done) begin
            s     <= root_res.root;
            exact <= root_res.exact;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            t    <= div_res.quot;
            step <= '0;
          end else begin
            step <= 3'd1;
          end
        end
        S_MOVE: begin
          step <= step + 3'd1;
          if (step != 3'd0) begin
            if (moved > 36'sh0_7FFF_FFFF) begin
              cur_c[pidx] <= 32'sh7FFF_FFFF;
              sat_r       <= 1'b1;
            end else if (moved < -36'sh0_8000_0000) begin
              cur_c[pidx] <= -32'sh8000_0000;
              sat_r       <= 1'b1;
            end else begin
              cur_c[pidx] <= CoordW'(moved);
            end
          end
        end
        S_RAD: begin
          grew_r <= 1'b1;
          if (rad_sum[RootW+1:1] > (RootW+1)'(31'h7FFF_FFFF)) begin
            cur_radius <= 31'h7FFF_FFFF;
            sat_r      <= 1'b1;
          end else begin
            cur_radius <= RadW'(rad_sum[RootW+1:1]);
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid    <= 1'b1;
            out_center_x <= cur_c[0];
            out_center_y <= cur_c[1];
            out_center_z <= cur_c[2];
            out_radius   <= cur_radius;
            grew         <= grew_r && (op_t'(op) == OP_MERGE);
            saturated    <= sat_r;
          end
        end
        default: step <= '0;
      endcase
    end
  end

endmodule

FILE: rtl/core/bsm_mul.sv
module bsm_mul (
  input  logic                      clk,
  input  logic [bsm_pkg::DiffW-1:0] a,
  input  logic [bsm_pkg::DiffW-1:0] b,
  output logic [bsm_pkg::ProdW-1:0] p
);
  import bsm_pkg::*;

  always_ff @(posedge clk) begin
    p <= ProdW'(a) * ProdW'(b);
  end

endmodule

FILE: rtl/core/bsm_isqrt.sv
module bsm_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bsm_pkg::LenW-1:0] value,
  output bsm_pkg::root_res_t       res
);
  import bsm_pkg::*;

  localparam int RemW = RootW + 2;

  logic [LenW-1:0]  val_sh;
  logic [RootW-1:0] root;
  logic [RemW-1:0]  rem;
  logic [5:0]       cnt;
  logic             busy;
  logic             done;
  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             take;

  always_comb begin
    rem_sh = {rem, val_sh[LenW-1 -: 2]};
    trial  = (RemW+2)'({root, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(RootW);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_sh <= value;
      root   <= '0;
      rem    <= '0;
    end else if (busy) begin
      val_sh <= {val_sh[LenW-3:0], 2'b00};
      root   <= {root[RootW-2:0], take};
      rem    <= take ? RemW'(rem_sh - trial) : RemW'(rem_sh);
    end
  end

  assign res.done  = done;
  assign res.root  = root;
  assign res.exact = (rem == '0);

endmodule

FILE: rtl/core/bsm_div.sv
module bsm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bsm_pkg::RootW:0]     num,
  input  logic [bsm_pkg::RootW-1:0]   den,
  output bsm_pkg::div_res_t           res
);
  import bsm_pkg::*;

  localparam int RmW = RootW + 1;

  logic [RmW-1:0]   rm;
  logic [RootW-1:0] q;
  logic [RootW-1:0] dv;
  logic [5:0]       cnt;
  logic             busy;
  logic             done;
  logic             shift_en;
  logic [RmW:0]     x;
  logic [RootW-1:0] qb;
  logic             take;

  // first two steps subtract in place, the remaining 31 shift first
  always_comb begin
    shift_en = (cnt <= 6'd31);
    x        = shift_en ? {rm, 1'b0} : {1'b0, rm};
    qb       = shift_en ? {q[RootW-2:0], 1'b0} : q;
    take     = (x >= (RmW+1)'(dv));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rm <= num;
      q  <= '0;
      dv <= den;
    end else if (busy) begin
      rm <= take ? RmW'(x - (RmW+1)'(dv)) : RmW'(x);
      q  <= qb + RootW'(take);
    end
  end

  assign res.done = done;
  assign res.quot = q;

endmodule

FILE: rtl/core/bsm_checker.sv
module bsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [30:0] out_radius,
  input logic        grew,
  input logic        saturated
);

  // one request in flight: stall rises right after an accept
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while busy");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(out_radius)))
    else $error("stalled result changed");

  a_sat_grew: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && saturated) |-> grew)
    else $error("saturated without growth");

  // no result without a request since the last one
  a_no_rsp_idle: assert property (@(posedge clk) disable iff (rst)
    (!req_stall && !$past(req_stall) && !$past(rsp_valid)) |-> !rsp_valid)
    else $error("result with no request");

endmodule

bind bounding_sphere_merge_top bsm_checker u_bsm_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .rsp_valid  (rsp_valid),
  .rsp_stall  (rsp_stall),
  .out_radius (out_radius),
  .grew       (grew),
  .saturated  (saturated)
);

FILE: tb/bounding_sphere_merge_top_tb.sv
module bounding_sphere_merge_top_tb;
  import bsm_pkg::*;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        rad;
    logic               grew;
    logic               sat;
  } sphere_res_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  logic               operation;
  logic signed [31:0] in_center_x;
  logic signed [31:0] in_center_y;
  logic signed [31:0] in_center_z;
  logic [30:0]        in_radius;
  logic               rsp_valid;
  logic               rsp_stall;
  logic signed [31:0] out_center_x;
  logic signed [31:0] out_center_y;
  logic signed [31:0] out_center_z;
  logic [30:0]        out_radius;
  logic               grew;
  logic               saturated;

  bounding_sphere_merge_top dut (.*);

  // predictor copy of the held sphere
  logic signed [63:0] hold_x, hold_y, hold_z;
  logic [63:0]        hold_r;
  sphere_res_t        expected_q[$];
  int                 mismatch_count;
  int                 sent_count;
  int                 merge_count;
  int                 grow_count;
  int                 sat_count;
  int                 enclose_count;
  bit                 idle_on;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [63:0] floor_root(input logic [65:0] v, output bit exact);
    logic [65:0] rem, trial;
    logic [63:0] root;
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
      trial = {root, 2'b01};
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    exact = (rem == 0);
    return root;
  endfunction

  function automatic logic signed [63:0] shift_axis(input logic signed [63:0] c,
      input logic signed [63:0] d, input logic [63:0] t, inout bit sat);
    logic [63:0]        ad;
    logic [127:0]       off;
    logic signed [63:0] v;
    ad = d < 0 ? -d : d;
    off = ({64'd0, ad} * {64'd0, t} + 128'h8000_0000) >> 32;
    v = d < 0 ? c - $signed(off[63:0]) : c + $signed(off[63:0]);
    if (v > 64'sd2147483647) begin
      sat = 1;
      v = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      sat = 1;
      v = -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic sphere_res_t merge_sphere(input op_t op, input logic signed [31:0] nx,
      input logic signed [31:0] ny, input logic signed [31:0] nz, input logic [30:0] nr);
    sphere_res_t        res;
    logic signed [63:0] dx, dy, dz;
    logic [65:0]        lensq, rdsq;
    logic [63:0]        r, r2, rd, s, n, t, rm, rad;
    bit                 exact, g, sat;
    g = 0;
    sat = 0;
    if (op == OP_START) begin
      hold_x = nx;
      hold_y = ny;
      hold_z = nz;
      hold_r = nr;
    end else begin
      dx = nx - hold_x;
      dy = ny - hold_y;
      dz = nz - hold_z;
      // squares reach past the signed 64-bit range, so treat them as unsigned
      lensq = 66'($unsigned(dx * dx)) + 66'($unsigned(dy * dy))
              + 66'($unsigned(dz * dz));
      r = hold_r;
      r2 = nr;
      rd = r > r2 ? r - r2 : r2 - r;
      rdsq = 66'(rd * rd);
      if (lensq <= rdsq) begin
        enclose_count++;
        if (r2 > r) begin
          hold_x = nx;
          hold_y = ny;
          hold_z = nz;
          hold_r = nr;
          g = 1;
        end
      end else begin
        s = floor_root(lensq, exact);
        n = s + r2 - r;
        t = 0;
        rm = n;
        if (rm >= s) begin rm -= s; t++; end
        if (rm >= s) begin rm -= s; t++; end
        for (int i = 0; i < 31; i++) begin
          rm = rm << 1;
          t = t << 1;
          if (rm >= s) begin
            rm -= s;
            t[0] = 1'b1;
          end
        end
        hold_x = shift_axis(hold_x, dx, t, sat);
        hold_y = shift_axis(hold_y, dy, t, sat);
        hold_z = shift_axis(hold_z, dz, t, sat);
        rad = (s + (exact ? 0 : 1) + r + r2 + 1) >> 1;
        if (rad > 64'h7FFF_FFFF) begin
          rad = 64'h7FFF_FFFF;
          sat = 1;
        end
        hold_r = rad;
        g = 1;
      end
    end
    res.cx = hold_x[31:0];
    res.cy = hold_y[31:0];
    res.cz = hold_z[31:0];
    res.rad = hold_r[30:0];
    res.grew = g;
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  // result checker
  initial begin
    sphere_res_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected response", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_center_x !== want.cx) report_mismatch("center_x", out_center_x, want.cx);
          if (out_center_y !== want.cy) report_mismatch("center_y", out_center_y, want.cy);
          if (out_center_z !== want.cz) report_mismatch("center_z", out_center_z, want.cz);
          if (out_radius !== want.rad)
            report_mismatch("radius", 32'(out_radius), 32'(want.rad));
          if (grew !== want.grew) report_mismatch("grew", 32'(grew), 32'(want.grew));
          if (saturated !== want.sat)
            report_mismatch("saturated", 32'(saturated), 32'(want.sat));
          if (want.grew) grow_count++;
          if (want.sat) sat_count++;
        end
      end
    end
  end

  // response back-pressure in random bursts
  initial begin
    rsp_stall = 0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        rsp_stall <= 0;
      end
    end
  end

  task automatic send_sphere(input op_t op, input logic signed [31:0] x,
      input logic signed [31:0] y, input logic signed [31:0] z, input logic [30:0] r);
    // the block stalls after each accept
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 18)) @(negedge clk);
    req_valid <= 1;
    operation <= op;
    in_center_x <= x;
    in_center_y <= y;
    in_center_z <= z;
    in_radius <= r;
    do @(posedge clk); while (req_stall);
    expected_q.push_back(merge_sphere(op, x, y, z, r));
    sent_count++;
    if (op == OP_MERGE) merge_count++;
    @(negedge clk);
    req_valid <= 0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 4000) - 2000;
      2: return $urandom_range(0, 32'h7FFF) << $urandom_range(0, 16);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 99)
                                           : 32'h8000_0000 + $urandom_range(0, 99);
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 5000));
      2: return 31'($urandom_range(0, 32'h7FFF) << $urandom_range(0, 15));
      default: return 31'(32'h7FFF_FFFF - $urandom_range(0, 99));
    endcase
  endfunction

  task automatic test_directed();
    send_sphere(OP_MERGE, 100, -200, 300, 50);          // merge on the reset sphere
    send_sphere(OP_START, 0, 0, 0, 1000);
    send_sphere(OP_MERGE, 10, 10, 10, 5);               // current encloses new
    send_sphere(OP_MERGE, 20, 0, 0, 5000);              // new encloses current
    send_sphere(OP_MERGE, 5000, 0, 0, 5000);            // overlapping pair, exact root
    send_sphere(OP_MERGE, 9000, 3, 7, 17);
    send_sphere(OP_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_sphere(OP_MERGE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_sphere(OP_START, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_sphere(OP_MERGE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_sphere(OP_START, 0, 0, 0, 0);
    send_sphere(OP_MERGE, 0, 0, 0, 0);                  // identical points
    send_sphere(OP_MERGE, 1, 0, 0, 0);
    send_sphere(OP_MERGE, -1, -1, -1, 31'h5555_5555);
    send_sphere(OP_MERGE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 31'h2AAA_AAAA);
    send_sphere(OP_START, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_sphere(OP_MERGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
  endtask

  task automatic test_random(input int count);
    int   since_start;
    op_t  op;
    since_start = 0;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 5) == 0 || since_start > 8) ? OP_START : OP_MERGE;
      since_start = (op == OP_START) ? 0 : since_start + 1;
      send_sphere(op, rand_coord(), rand_coord(), rand_coord(), rand_radius());
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_sphere(OP_MERGE, rand_coord(), rand_coord(), rand_coord(), rand_radius());
  endtask

  initial begin
    idle_on = 1;
    mismatch_count = 0;
    sent_count = 0;
    merge_count = 0;
    grow_count = 0;
    sat_count = 0;
    enclose_count = 0;
    hold_x = 0;
    hold_y = 0;
    hold_z = 0;
    hold_r = 0;
    rst = 1;
    req_valid = 0;
    operation = 0;
    in_center_x = 0;
    in_center_y = 0;
    in_center_z = 0;
    in_radius = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_random(500);
    test_drain_pause();
    test_random(200);
    idle_on = 0;
    test_random(150);
    wait_drained();
    repeat (200) @(negedge clk);
    $display("sent %0d requests, %0d merges: %0d grew, %0d saturated, %0d enclosed",
             sent_count, merge_count, grow_count, sat_count, enclose_count);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bsm_pkg.sv
rtl/core/bsm_mul.sv
rtl/core/bsm_isqrt.sv
rtl/core/bsm_div.sv
rtl/core/bounding_sphere_merge_top.sv
rtl/core/bsm_checker.sv
tb/bounding_sphere_merge_top_tb.sv
